FILE: rtl/rets_pkg.sv
`default_nettype none
package rets_pkg;
  localparam int unsigned MaxTasks = 4;
  localparam int unsigned Slots = 4;

  typedef enum logic [2:0] {
    K_RUN  = 3'd0,
    K_IDLE = 3'd1,
    K_FIN  = 3'd2,
    K_PRE  = 3'd3,
    K_LOST = 3'd4,
    K_KILL = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    REG_MODE  = 3'd0,
    REG_COUNT = 3'd1,
    REG_T0    = 3'd2,
    REG_T1    = 3'd3,
    REG_T2    = 3'd4,
    REG_T3    = 3'd5
  } reg_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DIS, S_REL, S_PICK, S_PRE, S_RUN, S_KILL, S_STAT, S_OUT, S_DONE
  } state_t;

  function automatic logic [15:0] inc16(input logic [15:0] v);
    inc16 = (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction
endpackage
`default_nettype wire

FILE: rtl/rms_edf_tick_scheduler_unit.sv
// order: per tick the lost-deadline words come first, then a preemption word, then a finish
//   word, then on a final tick the kill words, and last the status word with m_tlast set
// ticks: one tick at a time; s_tready is low from an accepted tick word until the status
//   word of that tick has been taken
// the slot scans share one slot view, one slot per cycle while no output word is pending
// reset: synchronous active-high rst clears task state, counters, mode and task registers, sets task_count to 1
`default_nettype none
module rms_edf_tick_scheduler_unit
  import rets_pkg::*;
#(
  parameter int unsigned MAX_TASKS = MaxTasks
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,   // final_tick
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [71:0] m_tdata,   // kind, task_index, segment_units, event_count, tick_time
  output logic        m_tlast,   // last_of_tick
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [2:0]  cfg_index,
  input  wire  [31:0] cfg_data
);
  localparam int unsigned NumSlots = (MAX_TASKS < Slots) ? MAX_TASKS : Slots;

  // configuration
  logic        mode;
  logic [2:0]  task_count;
  logic [31:0] task_reg [Slots];

  // task state
  logic [15:0] rem   [Slots];
  logic [15:0] cdown [Slots];
  logic [15:0] ccnt  [Slots];
  logic [15:0] lcnt  [Slots];
  logic [15:0] kcnt  [Slots];
  logic [2:0]  run_slot;
  logic [15:0] seg_len;
  logic [15:0] idle_len;
  logic [31:0] cur_tick;

  // sequencer
  state_t      state, state_next;
  logic [1:0]  idx;
  logic [2:0]  best;
  logic        fin;
  logic [2:0]  st_kind;
  logic [1:0]  st_idx;
  logic [15:0] st_seg;
  logic [15:0] st_cnt;

  logic [2:0] cnt_clamp;
  assign cnt_clamp = (task_count > 3'(NumSlots)) ? 3'(NumSlots) : task_count;

  function automatic logic slot_on(input logic [2:0] i, input logic [2:0] c,
                                   input logic [15:0] per);
    slot_on = (i < c) && (per != 16'd0);
  endfunction

  // shared slot view for the current scan index
  logic [15:0] per_i, bur_i, per_b;
  logic        on_i;
  logic        better;
  assign per_i = task_reg[idx][31:16];
  assign bur_i = task_reg[idx][15:0];
  assign per_b = task_reg[best[1:0]][31:16];
  assign on_i  = slot_on({1'b0, idx}, cnt_clamp, per_i);
  always_comb begin
    if (mode && cdown[idx] != cdown[best[1:0]]) better = cdown[idx] < cdown[best[1:0]];
    else better = per_i < per_b;
  end

  logic last_idx;
  assign last_idx = (idx == 2'(Slots - 1));

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (s_tvalid) state_next = S_DIS;
      S_DIS:  state_next = S_REL;
      S_REL:  if (!m_tvalid && last_idx && !(on_i && cdown[idx] == 0 && rem[idx] != 0))
                state_next = S_PICK;
      S_PICK: if (last_idx) state_next = S_PRE;
      S_PRE:  if (!m_tvalid) state_next = S_RUN;
      S_RUN:  if (!m_tvalid) state_next = fin ? S_KILL : S_STAT;
      S_KILL: if (!m_tvalid && last_idx) state_next = S_STAT;
      S_STAT: if (!m_tvalid) state_next = S_DONE;
      S_DONE: if (!m_tvalid) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // datapath and output word
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode <= 1'b0;
      task_count <= 3'd1;
      for (int i = 0; i < Slots; i++) begin
        task_reg[i] <= '0; rem[i] <= '0; cdown[i] <= '0;
        ccnt[i] <= '0; lcnt[i] <= '0; kcnt[i] <= '0;
      end
      run_slot <= 3'd4;
      seg_len <= '0;
      idle_len <= '0;
      cur_tick <= '0;
      m_tvalid <= 1'b0;
      idx <= '0;
      best <= 3'd4;
      fin <= 1'b0;
    end else begin
      state <= state_next;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            unique case (cfg_index)
              REG_MODE:  mode <= cfg_data[0];
              REG_COUNT: task_count <= cfg_data[2:0];
              REG_T0:    task_reg[0] <= cfg_data;
              REG_T1:    task_reg[1] <= cfg_data;
              REG_T2:    task_reg[2] <= cfg_data;
              REG_T3:    task_reg[3] <= cfg_data;
              default: ;
            endcase
          end
          if (s_tvalid) fin <= s_tdata[0];
          idx <= '0;
        end
        // running slot disabled: end segment silently
        S_DIS: begin
          if (run_slot < 3'd4 &&
              !slot_on(run_slot, cnt_clamp, task_reg[run_slot[1:0]][31:16])) begin
            run_slot <= 3'd4;
            seg_len <= '0;
          end
        end
        // release scan, one slot a cycle while no output word is pending, lost-deadline words
        S_REL: if (!m_tvalid) begin
          if (on_i) begin
            if (cdown[idx] == 0) begin
              if (rem[idx] != 0) begin
                lcnt[idx] <= inc16(lcnt[idx]);
                m_tvalid <= 1'b1;
                m_tdata <= {3'd0, cur_tick, inc16(lcnt[idx]),
                            (run_slot == {1'b0, idx}) ? seg_len : 16'd0, idx, K_LOST};
                m_tlast <= 1'b0;
                if (run_slot == {1'b0, idx}) begin
                  run_slot <= 3'd4;
                  seg_len <= '0;
                end
                rem[idx] <= 16'd0;
              end else begin
                rem[idx] <= bur_i;
                cdown[idx] <= per_i - 16'd1;
                idx <= idx + 2'd1;
              end
            end else begin
              cdown[idx] <= cdown[idx] - 16'd1;
              idx <= idx + 2'd1;
            end
          end else idx <= idx + 2'd1;
          if (last_idx && !(on_i && cdown[idx] == 0 && rem[idx] != 0)) best <= 3'd4;
        end
        // selection scan over the shared compare
        S_PICK: begin
          if (on_i && rem[idx] != 0 && (best == 3'd4 || better)) best <= {1'b0, idx};
          idx <= idx + 2'd1;
        end
        S_PRE: if (!m_tvalid) begin
          if (run_slot < 3'd4 && run_slot != best) begin
            if (rem[run_slot[1:0]] != 0) begin
              m_tvalid <= 1'b1;
              m_tdata <= {3'd0, cur_tick, 16'd0, seg_len, run_slot[1:0], K_PRE};
              m_tlast <= 1'b0;
            end
            run_slot <= 3'd4;
            seg_len <= '0;
          end
        end
        S_RUN: if (!m_tvalid) begin
          idx <= '0;
          if (best < 3'd4) begin
            st_kind <= K_RUN;
            st_idx <= best[1:0];
            st_seg <= inc16((run_slot != best) ? 16'd0 : seg_len);
            idle_len <= '0;
            rem[best[1:0]] <= rem[best[1:0]] - 16'd1;
            if (rem[best[1:0]] == 16'd1) begin
              ccnt[best[1:0]] <= inc16(ccnt[best[1:0]]);
              st_cnt <= inc16(ccnt[best[1:0]]);
              m_tvalid <= 1'b1;
              m_tdata <= {3'd0, cur_tick, inc16(ccnt[best[1:0]]),
                          inc16((run_slot != best) ? 16'd0 : seg_len), best[1:0], K_FIN};
              m_tlast <= 1'b0;
              run_slot <= 3'd4;
              seg_len <= '0;
            end else begin
              st_cnt <= ccnt[best[1:0]];
              run_slot <= best;
              seg_len <= inc16((run_slot != best) ? 16'd0 : seg_len);
            end
          end else begin
            idle_len <= inc16(idle_len);
            st_kind <= K_IDLE;
            st_idx <= '0;
            st_seg <= inc16(idle_len);
            st_cnt <= '0;
          end
        end
        // kill scan on the final tick
        S_KILL: if (!m_tvalid) begin
          if (on_i && rem[idx] != 0) begin
            kcnt[idx] <= inc16(kcnt[idx]);
            m_tvalid <= 1'b1;
            m_tdata <= {3'd0, cur_tick, inc16(kcnt[idx]),
                        (run_slot == {1'b0, idx}) ? seg_len : 16'd0, idx, K_KILL};
            m_tlast <= 1'b0;
            rem[idx] <= '0;
          end
          idx <= idx + 2'd1;
          if (last_idx) begin
            run_slot <= 3'd4;
            seg_len <= '0;
          end
        end
        S_STAT: if (!m_tvalid) begin
          m_tvalid <= 1'b1;
          m_tdata <= {3'd0, cur_tick, st_cnt, st_seg, st_idx, st_kind};
          m_tlast <= 1'b1;
        end
        S_DONE: if (!m_tvalid) begin
          if (cur_tick != 32'hFFFF_FFFF) cur_tick <= cur_tick + 32'd1;
        end
        default: ;
      endcase
    end
  end

  // output word holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast));

  // a new tick is taken only with the output empty
  a_in_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid);

  // slot pointers stay in range
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    run_slot <= 3'd4 && best <= 3'd4);

  // the word closing a tick is a status word
  a_status_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> (m_tdata[2:0] == K_RUN || m_tdata[2:0] == K_IDLE));
endmodule
`default_nettype wire
